/* src/nllp_pkg.sv */
package nllp_pkg;

	localparam int unsigned FRAC_BITS = 24;
	localparam logic [29:0] PADE_A = 30'(27 * (1 << FRAC_BITS));
	localparam logic [3:0] PADE_B = 4'd9;
	localparam logic signed [26:0] SAT_LIM = 27'sd50331648;
	localparam logic [31:0] UPD_DIV = 32'd6;

	typedef struct packed {
		logic [3:0] voice;
		logic signed [31:0] sample_in;
		logic [17:0] cutoff_step;
		logic [15:0] resonance;
	} req_t;

	typedef struct packed {
		logic [3:0] voice_out;
		logic signed [31:0] lowpass_out;
	} rsp_t;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_LOAD = 13'b0000000000010,
		ST_FB   = 13'b0000000000100,
		ST_PRE  = 13'b0000000001000,
		ST_SQ   = 13'b0000000010000,
		ST_NUM  = 13'b0000000100000,
		ST_DVS  = 13'b0000001000000,
		ST_DIV  = 13'b0000010000000,
		ST_SLP  = 13'b0000100000000,
		ST_SLK  = 13'b0001000000000,
		ST_D6   = 13'b0010000000000,
		ST_UPD  = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [26:0] clamp3(input logic signed [53:0] v);
		logic signed [26:0] r;
		if (v > 54'(SAT_LIM)) begin
			r = SAT_LIM;
		end else if (v < -54'(SAT_LIM)) begin
			r = -SAT_LIM;
		end else begin
			r = v[26:0];
		end
		return r;
	endfunction

endpackage

/* src/nllp_ram.sv */
module nllp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/nonlinear_ladder_lowpass_rk4.sv */
// Four-pole nonlinear ladder low-pass for up to VOICES voices, advanced by one fourth-order
// Runge-Kutta step per transfer. req_ready is low from acceptance until the result has been
// written to the output register, so a new item is accepted only once the last one is through;
// an item for a voice at or above VOICES goes straight to the done state, which writes a zero
// result once the output register is free. The pace is set by one shared 32x32 multiplier and
// one three-bit-per-cycle divider: each of the four slope evaluations runs five saturator
// divisions, and the final update four more. Stage values live in a RAM of
// VOICES*4 words; a per-voice valid bit makes every voice read as zero after reset, so no
// clearing pass is needed. A finished result may wait in the output register while the next
// item is accepted.
module nonlinear_ladder_lowpass_rk4 import nllp_pkg::*; #(
	parameter int VOICES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = VW + 2;
	localparam logic [3:0] DIV_LAST = 4'd10;

	state_t state_q;
	logic [3:0] voice_q;
	logic signed [31:0] u_q;
	logic [17:0] h_q;
	logic [15:0] r_q;
	logic [VW-1:0] vi_q;
	logic [VOICES-1:0] vld_q;
	logic [2:0] ld_q;
	logic [2:0] j_q;
	logic [1:0] i_q;
	logic [1:0] e_q;
	logic [3:0] dc_q;
	logic mode_q;
	logic signed [31:0] s_q [4];
	logic signed [31:0] t_q [4];
	logic signed [32:0] acc_q [4];
	logic signed [26:0] y_q [5];
	logic signed [26:0] x_q;
	logic [31:0] den_q;
	logic signed [63:0] prod_q;
	logic [32:0] rem_q;
	logic [32:0] nlo_q;
	logic [32:0] quo_q;
	logic [31:0] dden_q;
	logic neg_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic [27:0] x2;
	logic [29:0] num;
	logic [31:0] den_c;
	logic signed [27:0] diff;
	logic signed [29:0] k_c;
	logic [32:0] rem_n;
	logic [32:0] nlo_n;
	logic [32:0] quo_n;
	logic signed [32:0] div_res;
	logic signed [32:0] div_fin;
	logic signed [63:0] pmag;
	logic [32:0] amag;
	logic signed [53:0] fb_x;
	logic [6:0] voice_ext;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [31:0] ram_wdata;
	logic [31:0] ram_rdata;
	logic signed [31:0] upd_val;
	logic rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign voice_ext = {3'b000, req.voice};
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FB: begin
				mul_a = t_q[3];
				mul_b = {16'b0, r_q};
			end
			ST_SQ: begin
				mul_a = {{5{x_q[26]}}, x_q};
				mul_b = {{5{x_q[26]}}, x_q};
			end
			ST_NUM: begin
				mul_a = {{5{x_q[26]}}, x_q};
				mul_b = {2'b00, num};
			end
			ST_SLP: begin
				mul_a = {14'b0, h_q};
				mul_b = {{4{diff[27]}}, diff};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign x2 = prod_q[51:24];
	assign num = PADE_A + {2'b00, x2};
	assign den_c = {2'b00, PADE_A} + 32'(x2) * {28'b0, PADE_B};
	assign diff = {y_q[{1'b0, i_q}][26], y_q[{1'b0, i_q}]}
		- {y_q[{1'b0, i_q} + 3'd1][26], y_q[{1'b0, i_q} + 3'd1]};
	assign k_c = prod_q[45:16];
	assign pmag = prod_q[63] ? -prod_q : prod_q;
	assign amag = acc_q[i_q][32] ? 33'(-acc_q[i_q]) : acc_q[i_q];
	assign fb_x = {{22{u_q[31]}}, u_q} - 54'(prod_q >>> 12);

	always_comb begin
		rem_n = rem_q;
		nlo_n = nlo_q;
		quo_n = quo_q;
		for (int b = 0; b < 3; b++) begin
			rem_n = {rem_n[31:0], nlo_n[32]};
			nlo_n = {nlo_n[31:0], 1'b0};
			quo_n = {quo_n[31:0], 1'b0};
			if (rem_n >= {1'b0, dden_q}) begin
				rem_n = rem_n - {1'b0, dden_q};
				quo_n[0] = 1'b1;
			end
		end
	end

	assign div_res = neg_q ? -$signed(quo_n) : $signed(quo_n);
	assign div_fin = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign upd_val = sat32(40'(s_q[i_q]) + 40'(div_fin));

	assign ram_we = (state_q == ST_UPD);
	assign ram_waddr = {vi_q, i_q};
	assign ram_wdata = upd_val;
	assign ram_raddr = {vi_q, ld_q[1:0]};

	nllp_ram #(
		.WIDTH(32),
		.DEPTH(VOICES * 4)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				voice_q <= req.voice;
				u_q <= req.sample_in;
				h_q <= req.cutoff_step;
				r_q <= req.resonance;
				vi_q <= voice_ext[VW-1:0];
			end
			ST_LOAD: begin
				if (ld_q != 3'd0) begin
					s_q[ld_q[1:0] - 2'd1] <= vld_q[vi_q] ? $signed(ram_rdata) : '0;
					t_q[ld_q[1:0] - 2'd1] <= vld_q[vi_q] ? $signed(ram_rdata) : '0;
				end
				for (int n = 0; n < 4; n++) begin
					acc_q[n] <= '0;
				end
			end
			ST_PRE: begin
				if (j_q == 3'd0) begin
					x_q <= clamp3(fb_x);
				end else begin
					x_q <= clamp3(54'(t_q[j_q[1:0] - 2'd1]));
				end
			end
			ST_NUM: begin
				den_q <= den_c;
			end
			ST_DVS: begin
				rem_q <= {8'b0, pmag[57:33]};
				nlo_q <= pmag[32:0];
				quo_q <= '0;
				dden_q <= den_q;
				neg_q <= prod_q[63];
			end
			ST_D6: begin
				rem_q <= '0;
				nlo_q <= amag;
				quo_q <= '0;
				dden_q <= UPD_DIV;
				neg_q <= acc_q[i_q][32];
			end
			ST_DIV: begin
				rem_q <= rem_n;
				nlo_q <= nlo_n;
				quo_q <= quo_n;
				if (dc_q == DIV_LAST && !mode_q) begin
					y_q[j_q] <= div_res[26:0];
				end
			end
			ST_SLK: begin
				if (e_q == 2'd0 || e_q == 2'd3) begin
					acc_q[i_q] <= acc_q[i_q] + 33'(k_c);
				end else begin
					acc_q[i_q] <= acc_q[i_q] + (33'(k_c) <<< 1);
				end
				if (e_q == 2'd2) begin
					t_q[i_q] <= sat32(40'(s_q[i_q]) + 40'(k_c));
				end else begin
					t_q[i_q] <= sat32(40'(s_q[i_q]) + 40'(k_c >>> 1));
				end
			end
			ST_UPD: begin
				s_q[i_q] <= upd_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_q <= '0;
			ld_q <= '0;
			j_q <= '0;
			i_q <= '0;
			e_q <= '0;
			dc_q <= '0;
			mode_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						ld_q <= '0;
						if (voice_ext < 7'(VOICES)) begin
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + 3'd1;
					if (ld_q == 3'd4) begin
						e_q <= '0;
						state_q <= ST_FB;
					end
				end
				ST_FB: begin
					j_q <= '0;
					state_q <= ST_PRE;
				end
				ST_PRE: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					state_q <= ST_DVS;
				end
				ST_DVS: begin
					mode_q <= 1'b0;
					dc_q <= '0;
					state_q <= ST_DIV;
				end
				ST_D6: begin
					mode_q <= 1'b1;
					dc_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dc_q <= dc_q + 4'd1;
					if (dc_q == DIV_LAST) begin
						if (mode_q) begin
							state_q <= ST_UPD;
						end else if (j_q == 3'd4) begin
							i_q <= '0;
							state_q <= ST_SLP;
						end else begin
							j_q <= j_q + 3'd1;
							state_q <= ST_PRE;
						end
					end
				end
				ST_SLP: begin
					state_q <= ST_SLK;
				end
				ST_SLK: begin
					i_q <= i_q + 2'd1;
					if (i_q != 2'd3) begin
						state_q <= ST_SLP;
					end else if (e_q != 2'd3) begin
						e_q <= e_q + 2'd1;
						state_q <= ST_FB;
					end else begin
						state_q <= ST_D6;
					end
				end
				ST_UPD: begin
					i_q <= i_q + 2'd1;
					if (i_q == 2'd3) begin
						vld_q[vi_q] <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_D6;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q.voice_out <= voice_q;
						rsp_q.lowpass_out <= ({3'b000, voice_q} < 7'(VOICES)) ? s_q[3] : '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/sv/testbench.sv */
module testbench;
	import nllp_pkg::*;

	localparam int NUM_VOICES = 16;
	localparam longint ONE_Q24 = 64'sd1 << 24;

	typedef longint quad_t[4];

	class ladder_scoreboard;
		longint stage[NUM_VOICES * 4];
		rsp_t expected_q[$];
		int errors;

		function new();
			foreach (stage[i]) stage[i] = 0;
			errors = 0;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint soft_clip(longint x);
			longint lim, sq, num, den;
			lim = 3 * ONE_Q24;
			if (x > lim) x = lim;
			if (x < -lim) x = -lim;
			sq = (x * x) >>> 24;
			num = 27 * ONE_Q24 + sq;
			den = 27 * ONE_Q24 + 9 * sq;
			return (x * num) / den;
		endfunction

		function quad_t ladder_slopes(quad_t s, longint u, longint r, longint h);
			quad_t k, y;
			longint drive;
			drive = soft_clip(u - ((r * s[3]) >>> 12));
			for (int i = 0; i < 4; i++) y[i] = soft_clip(s[i]);
			k[0] = (h * (drive - y[0])) >>> 16;
			for (int i = 1; i < 4; i++) k[i] = (h * (y[i - 1] - y[i])) >>> 16;
			return k;
		endfunction

		function void note_request(req_t item);
			quad_t s, t, k1, k2, k3, k4;
			longint u, h, r;
			rsp_t res;
			int base;
			res.voice_out = item.voice;
			if (item.voice >= NUM_VOICES) begin
				res.lowpass_out = '0;
				expected_q.push_back(res);
				return;
			end
			base = item.voice * 4;
			u = longint'(item.sample_in);
			h = longint'({1'b0, item.cutoff_step});
			r = longint'({1'b0, item.resonance});
			for (int i = 0; i < 4; i++) s[i] = stage[base + i];
			k1 = ladder_slopes(s, u, r, h);
			for (int i = 0; i < 4; i++) t[i] = clip32(s[i] + (k1[i] >>> 1));
			k2 = ladder_slopes(t, u, r, h);
			for (int i = 0; i < 4; i++) t[i] = clip32(s[i] + (k2[i] >>> 1));
			k3 = ladder_slopes(t, u, r, h);
			for (int i = 0; i < 4; i++) t[i] = clip32(s[i] + k3[i]);
			k4 = ladder_slopes(t, u, r, h);
			for (int i = 0; i < 4; i++)
				stage[base + i] = clip32(s[i] + (k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]) / 6);
			res.lowpass_out = 32'(stage[base + 3]);
			expected_q.push_back(res);
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp_res;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result voice %0d value %0d", $time,
					got.voice_out, got.lowpass_out);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (got.voice_out !== exp_res.voice_out) begin
				$display("%0t: voice_out expected %0d actual %0d", $time,
					exp_res.voice_out, got.voice_out);
				errors++;
			end
			if (got.lowpass_out !== exp_res.lowpass_out) begin
				$display("%0t: lowpass_out expected %0d actual %0d", $time,
					exp_res.lowpass_out, got.lowpass_out);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	ladder_scoreboard board = new();
	bit long_hold = 1'b0;

	nonlinear_ladder_lowpass_rk4 #(.VOICES(NUM_VOICES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) board.check_result(rsp);
		if (req_valid && req_ready) board.note_request(req);
	end

	task automatic send_item(req_t item, int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	function automatic req_t make_item(int v, longint smp, int cut, int res);
		req_t item;
		item.voice = 4'(v);
		item.sample_in = 32'(smp);
		item.cutoff_step = 18'(cut);
		item.resonance = 16'(res);
		return item;
	endfunction

	function automatic req_t random_item();
		req_t item;
		int pick;
		item.voice = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 9);
		if (pick < 6) item.sample_in = $signed(32'($urandom_range(0, 1 << 26))) - (1 << 25);
		else item.sample_in = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 7) item.cutoff_step = 18'($urandom_range(0, 40000));
		else item.cutoff_step = 18'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 8) item.resonance = 16'($urandom_range(0, 40960));
		else item.resonance = 16'($urandom);
		return item;
	endfunction

	initial begin
		req_t directed[$];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed.push_back(make_item(0, 0, 0, 0));
		directed.push_back(make_item(0, 64'sd16777216, 6554, 0));
		directed.push_back(make_item(0, 64'sd2147483647, 262143, 65535));
		directed.push_back(make_item(0, 64'sd2147483647, 262143, 65535));
		directed.push_back(make_item(0, -64'sd2147483648, 262143, 65535));
		directed.push_back(make_item(0, -64'sd2147483648, 262143, 0));
		directed.push_back(make_item(15, 64'sd2147483647, 262143, 0));
		directed.push_back(make_item(15, 64'sd2147483647, 262143, 0));
		directed.push_back(make_item(15, 64'sd2147483647, 262143, 40960));
		directed.push_back(make_item(15, -64'sd2147483648, 0, 40960));
		directed.push_back(make_item(7, 64'sd50331648, 131072, 40960));
		directed.push_back(make_item(7, -64'sd50331648, 131072, 40960));
		directed.push_back(make_item(7, 64'sd8388608, 65536, 65535));
		directed.push_back(make_item(3, -1, 1, 1));
		directed.push_back(make_item(3, 64'sd1, 262143, 32768));
		directed.push_back(make_item(8, 64'sd33554432, 20000, 16384));
		foreach (directed[i]) send_item(directed[i], $urandom_range(0, 14));
		for (int n = 0; n < 550; n++) begin
			if (n == 150) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (board.expected_q.size() != 0) @(posedge clk);
			end
			if (n == 300) long_hold = 1'b1;
			send_item(random_item(), (n % 100 < 15) ? 0 : $urandom_range(0, 14));
		end
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (board.errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				stall = 3000;
			end else begin
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end
endmodule

/* sim.f */
src/nllp_pkg.sv
src/nllp_ram.sv
src/nonlinear_ladder_lowpass_rk4.sv
tb/sv/testbench.sv
